/* rtl/sld_pkg.sv */
// Shared types, codes and constants of the sync/length/xor deframer.
package sld_pkg;

    localparam logic [7:0] SYNC_BYTE        = 8'h7E;
    localparam logic [7:0] MAX_PAYLOAD_RST  = 8'd200;
    localparam logic [8:0] HEADER_LAST_OFS  = 9'd3;
    localparam logic [8:0] TRAILER_OVERHEAD = 9'd4;

    localparam logic [7:0] ID_ACK = 8'h02;
    localparam logic [7:0] ID_NAK = 8'h03;
    localparam logic [7:0] ID_ID  = 8'h04;
    localparam logic [7:0] ID_HK  = 8'h20;
    localparam logic [7:0] ID_SDP = 8'h30;
    localparam logic [7:0] ID_CAL = 8'h33;

    // Configuration register indexes
    localparam logic CFG_ENABLE      = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_sld_phase;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_GOOD     = 3'd1,
        EV_SYNC_ERR = 3'd2,
        EV_SIZE_ERR = 3'd3,
        EV_XOR_ERR  = 3'd4
    } t_sld_event;

    typedef enum logic [2:0] {
        CL_ACK   = 3'd0,
        CL_NAK   = 3'd1,
        CL_ID    = 3'd2,
        CL_HK    = 3'd3,
        CL_SDP   = 3'd4,
        CL_CAL   = 3'd5,
        CL_OTHER = 3'd6
    } t_sld_class;

    // One classified byte, as handed from front to back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_frame;
        logic [8:0] byte_offset;
        t_sld_event event_res;
        logic [7:0] packet_id;
        logic [8:0] packet_length;
    } t_sld_rec;

    function automatic t_sld_class class_of(input logic [7:0] id);
        t_sld_class c;
        case (id)
            ID_ACK:  c = CL_ACK;
            ID_NAK:  c = CL_NAK;
            ID_ID:   c = CL_ID;
            ID_HK:   c = CL_HK;
            ID_SDP:  c = CL_SDP;
            ID_CAL:  c = CL_CAL;
            default: c = CL_OTHER;
        endcase
        return c;
    endfunction

endpackage

/* rtl/sld_front.sv */
// Front end: frame state machine that classifies each accepted byte.
module sld_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic [7:0]          i_max_payload,
    output sld_pkg::t_sld_rec   o_rec
);

    sld_pkg::t_sld_phase r_phase, n_phase;
    logic [8:0]          r_offset, n_offset;
    logic [7:0]          r_len, n_len;
    logic [7:0]          r_id, n_id;
    logic [7:0]          r_xor, n_xor;

    logic [7:0] id_cur;
    logic [7:0] len_cur;
    logic [8:0] last_ofs;

    // id and length bytes are visible on the byte that carries them
    assign id_cur   = (r_offset == 9'd1) ? i_rx_byte : r_id;
    assign len_cur  = (r_offset == 9'd2) ? i_rx_byte : r_len;
    assign last_ofs = {1'b0, r_len} + sld_pkg::TRAILER_OVERHEAD;

    always_comb begin
        n_phase  = r_phase;
        n_offset = r_offset;
        n_len    = r_len;
        n_id     = r_id;
        n_xor    = r_xor;

        o_rec.data_byte     = i_rx_byte;
        o_rec.in_frame      = 1'b0;
        o_rec.byte_offset   = '0;
        o_rec.event_res     = sld_pkg::EV_NONE;
        o_rec.packet_id     = '0;
        o_rec.packet_length = '0;

        case (r_phase)
            sld_pkg::PH_HEADER: begin
                o_rec.in_frame    = 1'b1;
                o_rec.byte_offset = r_offset;
                o_rec.packet_id   = id_cur;
                n_xor    = r_xor ^ i_rx_byte;
                n_id     = id_cur;
                n_len    = len_cur;
                n_offset = r_offset + 9'd1;
                if (r_offset >= sld_pkg::HEADER_LAST_OFS) begin
                    if (len_cur > i_max_payload) begin
                        o_rec.event_res = sld_pkg::EV_SIZE_ERR;
                        n_phase  = sld_pkg::PH_HUNT;
                        n_offset = '0;
                    end else begin
                        n_phase = sld_pkg::PH_PAYLOAD;
                    end
                end
            end
            sld_pkg::PH_PAYLOAD: begin
                o_rec.in_frame    = 1'b1;
                o_rec.byte_offset = r_offset;
                o_rec.packet_id   = r_id;
                if (r_offset >= last_ofs) begin
                    if (r_xor == i_rx_byte) begin
                        o_rec.event_res     = sld_pkg::EV_GOOD;
                        o_rec.packet_length = last_ofs + 9'd1;
                    end else begin
                        o_rec.event_res = sld_pkg::EV_XOR_ERR;
                    end
                    n_phase  = sld_pkg::PH_HUNT;
                    n_offset = '0;
                end else begin
                    n_xor    = r_xor ^ i_rx_byte;
                    n_offset = r_offset + 9'd1;
                end
            end
            default: begin
                n_phase  = sld_pkg::PH_HUNT;
                n_offset = '0;
                if (i_rx_byte == sld_pkg::SYNC_BYTE) begin
                    o_rec.in_frame = 1'b1;
                    n_phase  = sld_pkg::PH_HEADER;
                    n_offset = 9'd1;
                    n_xor    = '0;
                    n_id     = '0;
                    n_len    = '0;
                end else if (i_rx_byte != 8'd0) begin
                    o_rec.event_res = sld_pkg::EV_SYNC_ERR;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sld_pkg::PH_HUNT;
            r_offset <= '0;
            r_len    <= '0;
            r_id     <= '0;
            r_xor    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_len    <= n_len;
            r_id     <= n_id;
            r_xor    <= n_xor;
        end
    end

    a_hunt_ofs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == sld_pkg::PH_HUNT |-> r_offset == 9'd0)
        else $error("offset not cleared while hunting");

    a_header_ofs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == sld_pkg::PH_HEADER |-> (r_offset >= 9'd1 && r_offset <= 9'd3))
        else $error("header offset out of range");

    a_payload_ofs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == sld_pkg::PH_PAYLOAD |-> (r_offset >= 9'd4 && r_offset <= last_ofs))
        else $error("payload offset past trailer");

endmodule

/* rtl/sld_queue.sv */
// Small register queue between the classifying front and the reporting back.
module sld_queue #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sld_pkg::t_sld_rec i_rec,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output sld_pkg::t_sld_rec o_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sld_pkg::t_sld_rec r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

/* rtl/sld_back.sv */
// Back end: statistics counters, id class lookup and the output register.
module sld_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  sld_pkg::t_sld_rec i_rec,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output sld_pkg::t_sld_rec o_rec,
    output logic [2:0]        o_packet_class,
    output logic [15:0]       o_good_count,
    output logic [15:0]       o_sync_error_count,
    output logic [15:0]       o_size_error_count,
    output logic [15:0]       o_xor_error_count
);

    logic              r_valid;
    sld_pkg::t_sld_rec r_rec;
    sld_pkg::t_sld_class r_class;
    logic [15:0] r_good, n_good;
    logic [15:0] r_sync, n_sync;
    logic [15:0] r_size, n_size;
    logic [15:0] r_xerr, n_xerr;

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        n_good = r_good;
        n_sync = r_sync;
        n_size = r_size;
        n_xerr = r_xerr;
        case (i_rec.event_res)
            sld_pkg::EV_GOOD:     n_good = r_good + 16'd1;
            sld_pkg::EV_SYNC_ERR: n_sync = r_sync + 16'd1;
            sld_pkg::EV_SIZE_ERR: n_size = r_size + 16'd1;
            sld_pkg::EV_XOR_ERR:  n_xerr = r_xerr + 16'd1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_good  <= '0;
            r_sync  <= '0;
            r_size  <= '0;
            r_xerr  <= '0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_good  <= n_good;
            r_sync  <= n_sync;
            r_size  <= n_size;
            r_xerr  <= n_xerr;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec   <= i_rec;
            r_class <= sld_pkg::class_of(i_rec.packet_id);
        end
    end

    assign o_valid            = r_valid;
    assign o_rec              = r_rec;
    assign o_packet_class     = r_class;
    assign o_good_count       = r_good;
    assign o_sync_error_count = r_sync;
    assign o_size_error_count = r_size;
    assign o_xor_error_count  = r_xerr;

    a_stall_holds_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> $stable(r_good) && $stable(r_sync)
                               && $stable(r_size) && $stable(r_xerr))
        else $error("counters moved while result stalled");

    a_one_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> $countones({n_good != r_good, n_sync != r_sync,
                              n_size != r_size, n_xerr != r_xerr}) <= 1)
        else $error("more than one counter bumped by one byte");

endmodule

/* rtl/sync_length_xor_deframer.sv */
// Top level of the sync/length/xor byte deframer.
//
// Byte-serial deframer for frames of the form 0x7E, id, length, hdr3,
// payload[length], xor. One received byte is taken per transfer on the rx
// channel and exactly one result transfer leaves on the res channel for it:
// the byte echoed, whether it belongs to a frame, its frame offset (sync at
// 0), an event (good, sync error, size error, xor error), the frame id and
// its class, the total frame length on a good packet, and four wrapping
// 16-bit statistics counters as they stand after that byte. While hunting,
// zero bytes pass with no event and any other non-sync byte counts a sync
// error. A length byte above max_payload ends the frame on the byte at
// offset 3 with a size error. Rate: one byte per clock sustained while
// enabled and i_res_ready is high; the front state machine updates phase,
// offset and running xor once per accepted byte. The transfer writes the
// byte's result into the queue, from which it is loaded into the output
// register and offered on the res channel. A two-entry queue sits between
// the front and the output stage, so input keeps flowing while a result
// waits for i_res_ready, until the queue fills. Configuration:
// index 0 is enable (bit 0, reset 1; when 0 o_rx_ready is low and bytes stay
// upstream), index 1 is max_payload (reset 200). Write configuration only
// while the block is idle.
module sync_length_xor_deframer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // received bytes
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // results
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [7:0]  o_data_byte,
    output logic        o_in_frame,
    output logic [8:0]  o_byte_offset,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_packet_id,
    output logic [8:0]  o_packet_length,
    output logic [2:0]  o_packet_class,
    output logic [15:0] o_good_count,
    output logic [15:0] o_sync_error_count,
    output logic [15:0] o_size_error_count,
    output logic [15:0] o_xor_error_count
);

    logic       r_enable;
    logic [7:0] r_max_payload;

    logic              rx_xfer;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    sld_pkg::t_sld_rec front_rec;
    sld_pkg::t_sld_rec q_rec;
    sld_pkg::t_sld_rec out_rec;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b1;
            r_max_payload <= sld_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sld_pkg::CFG_ENABLE:      r_enable      <= i_cfg_data[0];
                sld_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accept whenever enabled and the queue has a free slot
    assign o_rx_ready = r_enable && !q_full;
    assign rx_xfer    = i_rx_valid && o_rx_ready;

    sld_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (rx_xfer),
        .i_rx_byte     (i_rx_byte),
        .i_max_payload (r_max_payload),
        .o_rec         (front_rec)
    );

    sld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rx_xfer),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    sld_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_rec              (q_rec),
        .o_pop              (q_pop),
        .o_valid            (o_res_valid),
        .i_ready            (i_res_ready),
        .o_rec              (out_rec),
        .o_packet_class     (o_packet_class),
        .o_good_count       (o_good_count),
        .o_sync_error_count (o_sync_error_count),
        .o_size_error_count (o_size_error_count),
        .o_xor_error_count  (o_xor_error_count)
    );

    assign o_data_byte     = out_rec.data_byte;
    assign o_in_frame      = out_rec.in_frame;
    assign o_byte_offset   = out_rec.byte_offset;
    assign o_event_res     = out_rec.event_res;
    assign o_packet_id     = out_rec.packet_id;
    assign o_packet_length = out_rec.packet_length;

    // a disabled block takes no bytes
    a_disabled_no_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enable |-> !rx_xfer)
        else $error("byte transferred while disabled");

    // length is reported only together with a good verdict
    a_len_only_on_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_packet_length != 9'd0 |-> o_event_res == sld_pkg::EV_GOOD)
        else $error("packet length without good verdict");

endmodule
